/* design/text_mode_character_scanout_top_macros.svh */
// ----------------------------------------------------------------------------
// text_mode_character_scanout_top_macros
// assertion macros used by the scanout top design file
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CHARACTER_SCANOUT_TOP_MACROS_SVH
`define TEXT_MODE_CHARACTER_SCANOUT_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define TMCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define TMCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/tmcs_pkg.sv */
// ----------------------------------------------------------------------------
// tmcs_pkg
// types, constants and control store of the text-mode character scanout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmcs_pkg;

  // default geometry
  localparam int unsigned SCREEN_DEPTH_DEF = 1024;
  localparam int unsigned TEXT_COLUMNS_DEF = 40;
  localparam int unsigned TEXT_CELLS_DEF   = 1000;
  localparam int unsigned GLYPH_HEIGHT_DEF = 8;
  localparam int unsigned GLYPH_COUNT      = 256;

  // characters fetched for one pixel word pair
  localparam int unsigned PAIR_CHARS = 8;

  // register reset values
  localparam logic [15:0] ACTIVE_PERIOD_RST = 16'd255;
  localparam logic [15:0] BLANK_PERIOD_RST  = 16'((3640 * 30) / 2 - 1);
  localparam logic [15:0] START_PERIOD_RST  = 16'((3285 + 3640 * 11 + 86 + 269) / 2 - 70 - 1);
  localparam logic [15:0] LINE_PERIOD_RST   = 16'd1820;

  // raster phases with a meaning of their own
  localparam logic [2:0] PHASE_BLANK    = 3'd0;
  localparam logic [2:0] PHASE_VSYNC    = 3'd1;
  localparam logic [2:0] PHASE_LINE_END = 3'd7;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_START     = 2'd1,
    CMD_SCREEN_WR = 2'd2,
    CMD_FONT_WR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_DISPLAY_VISIBLE = 3'd0,
    CFG_ACTIVE_PERIOD   = 3'd1,
    CFG_BLANK_PERIOD    = 3'd2,
    CFG_START_PERIOD    = 3'd3,
    CFG_LINE_PERIOD     = 3'd4
  } cfg_e;

  // sequencer
  typedef logic [2:0] upc_t;

  localparam upc_t U_COMMIT = 3'd0;  // apply state update, send result
  localparam upc_t U_FIRST  = 3'd1;  // first screen read
  localparam upc_t U_PRIME  = 3'd2;  // screen read, first font read
  localparam upc_t U_LOOP   = 3'd3;  // screen read, font read, shift
  localparam upc_t U_DRAIN  = 3'd4;  // last font read, shift
  localparam upc_t U_LAST   = 3'd5;  // last shift

  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_LOOP   = 2'd1,
    JMP_ALWAYS = 2'd2
  } jmp_e;

  typedef struct packed {
    logic scr_rd;
    logic fnt_rd;
    logic shift;
    logic commit;
    jmp_e jmp;
    upc_t target;
  } ucw_t;

  function automatic ucw_t ucode(upc_t pc);
    ucw_t w;
    w = '0;
    unique case (pc)
      U_COMMIT: begin
        w.commit = 1'b1;
      end
      U_FIRST: begin
        w.scr_rd = 1'b1;
      end
      U_PRIME: begin
        w.scr_rd = 1'b1;
        w.fnt_rd = 1'b1;
      end
      U_LOOP: begin
        w.scr_rd = 1'b1;
        w.fnt_rd = 1'b1;
        w.shift  = 1'b1;
        w.jmp    = JMP_LOOP;
        w.target = U_LOOP;
      end
      U_DRAIN: begin
        w.fnt_rd = 1'b1;
        w.shift  = 1'b1;
      end
      U_LAST: begin
        w.shift  = 1'b1;
        w.jmp    = JMP_ALWAYS;
        w.target = U_COMMIT;
      end
      default: begin
        w.commit = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* design/tmcs_ram.sv */
// ----------------------------------------------------------------------------
// tmcs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/text_mode_character_scanout_top.sv */
// sequencing: a tick that emits a pixel word pair runs the first, prime, loop, drain and last
//   steps, every other request (start, memory write, any other tick) goes straight to commit;
//   new requests wait for the commit, which waits for a free result register; glyph bytes use
//   the single read port of screen and font memory (eight reads each, overlapped by one step)
// reset: rst_ni asynchronous, low active; resets sequencer, raster state and configuration registers,
//   screen and font memory hold no defined contents until written
// ----------------------------------------------------------------------------
// text_mode_character_scanout_top
// microcoded text-mode scanout: timer phases, screen and font lookup, pixel words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_mode_character_scanout_top_macros.svh"

module text_mode_character_scanout_top #(
  parameter int unsigned SCREEN_DEPTH = tmcs_pkg::SCREEN_DEPTH_DEF,
  parameter int unsigned TEXT_COLUMNS = tmcs_pkg::TEXT_COLUMNS_DEF,
  parameter int unsigned TEXT_CELLS   = tmcs_pkg::TEXT_CELLS_DEF,
  parameter int unsigned GLYPH_HEIGHT = tmcs_pkg::GLYPH_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // mem_address[10:0], mem_data[18:11], zero fill
  input  logic [1:0]  s_axis_tuser_i,   // command[1:0]
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // next_period[15:0], timer_running[16],
                                        // vsync_end[17], pixel_word_first[49:18],
                                        // pixel_word_second[81:50], zero fill
  output logic [0:0]  m_axis_tuser_o,   // words_valid[0]
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // derived widths
  localparam int unsigned SAW        = $clog2(SCREEN_DEPTH);
  localparam int unsigned FONT_DEPTH = GLYPH_HEIGHT * tmcs_pkg::GLYPH_COUNT;
  localparam int unsigned FAW        = $clog2(FONT_DEPTH);
  localparam int unsigned GRW        = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int unsigned OFW        = $clog2(tmcs_pkg::PAIR_CHARS);
  localparam logic [OFW-1:0] OFF_LAST = OFW'(tmcs_pkg::PAIR_CHARS - 1);

  // ---------------------------------------------------------------------------
  // configuration registers, always ready
  // ---------------------------------------------------------------------------
  logic        visible_q;
  logic [15:0] active_q, blank_q, start_q, line_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visible_q <= 1'b1;
      active_q  <= tmcs_pkg::ACTIVE_PERIOD_RST;
      blank_q   <= tmcs_pkg::BLANK_PERIOD_RST;
      start_q   <= tmcs_pkg::START_PERIOD_RST;
      line_q    <= tmcs_pkg::LINE_PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (tmcs_pkg::cfg_e'(cfg_index_i))
        tmcs_pkg::CFG_DISPLAY_VISIBLE: visible_q <= cfg_data_i[0];
        tmcs_pkg::CFG_ACTIVE_PERIOD:   active_q  <= cfg_data_i;
        tmcs_pkg::CFG_BLANK_PERIOD:    blank_q   <= cfg_data_i;
        tmcs_pkg::CFG_START_PERIOD:    start_q   <= cfg_data_i;
        tmcs_pkg::CFG_LINE_PERIOD:     line_q    <= cfg_data_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // raster state
  // ---------------------------------------------------------------------------
  logic [2:0]     phase_q, phase_d;
  logic [SAW-1:0] char_addr_q, char_addr_d;
  logic [GRW-1:0] glyph_row_q, glyph_row_d;
  logic [15:0]    period_q, period_d;
  logic           running_q, running_d;

  // ---------------------------------------------------------------------------
  // request capture and sequencer
  // ---------------------------------------------------------------------------
  logic                 busy_q;
  tmcs_pkg::cmd_e       cmd_q;
  logic [10:0]          addr_q;
  logic [7:0]           data_q;
  tmcs_pkg::upc_t       upc_q, upc_d, upc_entry;
  logic [OFW-1:0]       off_q;
  tmcs_pkg::ucw_t       uw;
  logic                 in_fire, commit_fire, word_tick;
  logic [63:0]          acc_q;

  assign s_axis_tready_o = !busy_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // a running tick in phases two to six gathers eight glyph bytes first
  assign word_tick = (tmcs_pkg::cmd_e'(s_axis_tuser_i) == tmcs_pkg::CMD_TICK) && running_q
                     && (phase_q != tmcs_pkg::PHASE_BLANK) && (phase_q != tmcs_pkg::PHASE_VSYNC)
                     && (phase_q != tmcs_pkg::PHASE_LINE_END);
  assign upc_entry = word_tick ? tmcs_pkg::U_FIRST : tmcs_pkg::U_COMMIT;

  // control word of the current step
  assign uw = tmcs_pkg::ucode(upc_q);

  // commit waits while the previous result still sits in the output register
  assign commit_fire = busy_q && uw.commit && (!m_axis_tvalid_o || m_axis_tready_i);

  always_comb begin
    unique case (uw.jmp)
      tmcs_pkg::JMP_NEXT:   upc_d = upc_q + 3'd1;
      tmcs_pkg::JMP_LOOP:   upc_d = (off_q != OFF_LAST) ? uw.target : upc_q + 3'd1;
      tmcs_pkg::JMP_ALWAYS: upc_d = uw.target;
      default:              upc_d = uw.target;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= tmcs_pkg::U_COMMIT;
      off_q  <= '0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
      upc_q  <= upc_entry;
      off_q  <= '0;
    end else if (busy_q) begin
      if (uw.commit) begin
        if (commit_fire) begin
          busy_q <= 1'b0;
        end
      end else begin
        upc_q <= upc_d;
        if (uw.scr_rd) begin
          off_q <= off_q + OFW'(1);  // wraps back to zero after the eighth read
        end
      end
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= tmcs_pkg::cmd_e'(s_axis_tuser_i);
      addr_q <= s_axis_tdata_i[10:0];
      data_q <= s_axis_tdata_i[18:11];
    end
  end

  // ---------------------------------------------------------------------------
  // screen and font memory
  // ---------------------------------------------------------------------------
  logic [SAW:0]   scr_rsum, scr_wsum;
  logic [SAW-1:0] scr_raddr, scr_waddr;
  logic [FAW-1:0] fnt_raddr, fnt_waddr;
  logic [4:0]     font_row;
  logic [7:0]     scr_rdata, fnt_rdata;
  logic           scr_we, fnt_we;

  // character index wraps at the screen depth
  assign scr_rsum  = {1'b0, char_addr_q} + (SAW + 1)'(off_q);
  assign scr_raddr = (scr_rsum >= (SAW + 1)'(SCREEN_DEPTH)) ?
                     SAW'(scr_rsum - (SAW + 1)'(SCREEN_DEPTH)) : SAW'(scr_rsum);
  assign scr_wsum  = (SAW + 1)'(addr_q);
  assign scr_waddr = (scr_wsum >= (SAW + 1)'(SCREEN_DEPTH)) ?
                     SAW'(scr_wsum - (SAW + 1)'(SCREEN_DEPTH)) : SAW'(scr_wsum);

  // font row of a write folds modulo the glyph height
  always_comb begin
    font_row = {2'b00, addr_q[10:8]};
    for (int i = 0; i < 8; i++) begin
      if (font_row >= 5'(GLYPH_HEIGHT)) begin
        font_row = font_row - 5'(GLYPH_HEIGHT);
      end
    end
  end

  assign fnt_waddr = FAW'({font_row, addr_q[7:0]});
  assign fnt_raddr = FAW'({5'(glyph_row_q), scr_rdata});

  assign scr_we = commit_fire && (cmd_q == tmcs_pkg::CMD_SCREEN_WR);
  assign fnt_we = commit_fire && (cmd_q == tmcs_pkg::CMD_FONT_WR);

  tmcs_ram #(
    .WIDTH (8),
    .DEPTH (SCREEN_DEPTH)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (data_q),
    .re_i    (busy_q && uw.scr_rd),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  tmcs_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (fnt_we),
    .waddr_i (fnt_waddr),
    .wdata_i (data_q),
    .re_i    (busy_q && uw.fnt_rd),
    .raddr_i (fnt_raddr),
    .rdata_o (fnt_rdata)
  );

  // glyph bytes shift in from the bottom, first character ends in the top byte
  always_ff @(posedge clk_i) begin
    if (busy_q && uw.shift) begin
      acc_q <= {acc_q[55:0], fnt_rdata};
    end
  end

  // ---------------------------------------------------------------------------
  // commit: next raster state and result
  // ---------------------------------------------------------------------------
  logic [SAW:0]   adv_sum;
  logic [SAW-1:0] addr_adv, addr_rewind;
  logic [18:0]    line_used;
  logic [15:0]    line_fill;
  logic           vs_d, words_d;

  // advance by one word pair, rewind by one text row, both modulo the screen depth
  assign adv_sum     = {1'b0, char_addr_q} + (SAW + 1)'(tmcs_pkg::PAIR_CHARS);
  assign addr_adv    = (adv_sum >= (SAW + 1)'(SCREEN_DEPTH)) ?
                       SAW'(adv_sum - (SAW + 1)'(SCREEN_DEPTH)) : SAW'(adv_sum);
  assign addr_rewind = (char_addr_q >= SAW'(TEXT_COLUMNS)) ?
                       SAW'(char_addr_q - SAW'(TEXT_COLUMNS)) :
                       SAW'((SAW + 1)'(char_addr_q) + (SAW + 1)'(SCREEN_DEPTH - TEXT_COLUMNS));

  // line filler: line - ((period + 1) * 6 + 1), floored at zero
  assign line_used = {1'b0, period_q, 2'b00} + {2'b00, period_q, 1'b0} + 19'd7;
  assign line_fill = ({3'b000, line_q} > line_used) ? 16'({3'b000, line_q} - line_used) : 16'd0;

  always_comb begin
    phase_d     = phase_q;
    char_addr_d = char_addr_q;
    glyph_row_d = glyph_row_q;
    period_d    = period_q;
    running_d   = running_q;
    vs_d        = 1'b0;
    words_d     = 1'b0;
    unique case (cmd_q) inside
      tmcs_pkg::CMD_START: begin
        period_d  = start_q;
        running_d = 1'b1;
      end
      tmcs_pkg::CMD_SCREEN_WR, tmcs_pkg::CMD_FONT_WR: ;  // memory write only
      tmcs_pkg::CMD_TICK: begin
        if (running_q) begin
          case (phase_q)
            tmcs_pkg::PHASE_BLANK: begin
              period_d = blank_q;
              phase_d  = tmcs_pkg::PHASE_VSYNC;
            end
            tmcs_pkg::PHASE_VSYNC: begin
              phase_d = phase_q + 3'd1;
              vs_d    = 1'b1;
              if (!visible_q) begin
                running_d = 1'b0;
              end else begin
                period_d = active_q;
              end
            end
            tmcs_pkg::PHASE_LINE_END: begin
              phase_d  = tmcs_pkg::PHASE_VSYNC;
              period_d = line_fill;
              if (32'(glyph_row_q) + 32'd1 < 32'(GLYPH_HEIGHT)) begin
                glyph_row_d = glyph_row_q + GRW'(1);
                char_addr_d = addr_rewind;
              end else begin
                glyph_row_d = '0;
                // past the last text cell: stop and rewind the frame
                if (32'(char_addr_q) > 32'(TEXT_CELLS - 1)) begin
                  running_d   = 1'b0;
                  char_addr_d = '0;
                  phase_d     = tmcs_pkg::PHASE_BLANK;
                  period_d    = period_q;
                end
              end
            end
            default: begin
              phase_d     = phase_q + 3'd1;
              char_addr_d = addr_adv;
              words_d     = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tmcs_pkg::PHASE_BLANK;
      char_addr_q <= '0;
      glyph_row_q <= '0;
      period_q    <= '1;
      running_q   <= 1'b0;
    end else if (commit_fire) begin
      phase_q     <= phase_d;
      char_addr_q <= char_addr_d;
      glyph_row_q <= glyph_row_d;
      period_q    <= period_d;
      running_q   <= running_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic        out_valid_q;
  logic [15:0] out_period_q;
  logic        out_run_q, out_vs_q, out_words_q;
  logic [63:0] out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_fire) begin
      out_period_q <= period_d;
      out_run_q    <= running_d;
      out_vs_q     <= vs_d;
      out_words_q  <= words_d;
      out_pix_q    <= words_d ? acc_q : 64'd0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_pix_q[31:0], out_pix_q[63:32],
                            out_vs_q, out_run_q, out_period_q};
  assign m_axis_tuser_o  = out_words_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic commit_step, commit_stall;

  // commit step, and a commit held back by a full result register
  assign commit_step  = busy_q && uw.commit;
  assign commit_stall = commit_step && m_axis_tvalid_o && !m_axis_tready_i;

  `TMCS_ASSERT(a_commit_holds, commit_stall |=> commit_step, "stalled commit left its step")
  `TMCS_ASSERT(a_gather_complete, commit_step |-> (off_q == '0), "partial glyph gather")
  `TMCS_ASSERT_ALWAYS(a_addr_range, (32'(char_addr_q) < SCREEN_DEPTH), "address beyond screen")
  `TMCS_ASSERT_ALWAYS(a_row_range, (32'(glyph_row_q) < GLYPH_HEIGHT), "row beyond glyph height")

endmodule
